// ===== src/pdpt_pkg.sv =====
// ----------------------------------------------------------------------------
// pdpt_pkg
// Shared types and constants for the proximity dedupe point table: item
// layouts, command and status codes, controller states and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package pdpt_pkg;

    localparam int COORD_BITS      = 16;
    localparam int TABLE_DEPTH_DEF = 32;
    localparam int RADIUS_W        = 12;
    localparam int ENTRY_INDEX_W   = 5;
    localparam int ENTRY_COUNT_W   = 6;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd150;

    typedef enum logic [1:0] {
        CMD_OBSERVE    = 2'd0,
        CMD_REMOVE     = 2'd1,
        CMD_DUMP_RED   = 2'd2,
        CMD_DUMP_GREEN = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STS_UPDATED   = 3'd0,
        STS_INSERTED  = 3'd1,
        STS_FULL      = 3'd2,
        STS_REMOVED   = 3'd3,
        STS_NOT_FOUND = 3'd4,
        STS_ENTRY     = 3'd5,
        STS_EMPTY     = 3'd6
    } t_status;

    typedef struct packed {
        t_cmd                          command;
        logic                          color;
        logic signed [COORD_BITS-1:0]  x_pos;
        logic signed [COORD_BITS-1:0]  y_pos;
    } t_in_item;

    typedef struct packed {
        t_status                       status;
        logic [ENTRY_INDEX_W-1:0]      entry_index;
        logic signed [COORD_BITS-1:0]  out_x;
        logic signed [COORD_BITS-1:0]  out_y;
        logic [ENTRY_COUNT_W-1:0]      entry_count;
        logic                          last;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } t_point;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_START  = 3'd1,
        S_SCAN   = 3'd2,
        S_DECIDE = 3'd3,
        S_SHIFT  = 3'd4,
        S_EMIT   = 3'd5,
        S_DUMP   = 3'd6
    } t_state;

    typedef struct packed {
        logic capture;
        logic scan_start;
        logic scan_run;
        logic decide;
        logic shift_run;
        logic dump_start;
        logic dump_run;
        logic emit_load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_dump;
        logic is_remove;
        logic tbl_empty;
        logic found;
        logic scan_done;
        logic shift_done;
        logic out_free;
        logic dump_last;
    } t_dp_status;

endpackage

// ===== src/proximity_dedupe_point_table.sv =====
// ----------------------------------------------------------------------------
// proximity_dedupe_point_table
// Two insertion-ordered point tables (red and green) with radius matching.
//
// Input words carry a command, a color and an x/y point. Observe updates the
// first entry of the chosen table that lies within the match radius, or
// appends the point, or drops it when the table is full. Remove deletes the
// first matching red entry and moves later entries up. Dump lists a table.
// Each observe or remove gives one output word; a dump gives one word per
// entry (or a single empty word), with last set on the final one.
// The block handles one input word at a time. The scan reads one table entry
// per cycle from the point memory, and a remove hit then moves each later
// entry up before the result is emitted. While the receiver does not stall, a
// dump issues one word per cycle after its start state. The match radius is
// written through the configuration channel, which is always ready; write it
// only while the block is idle.
// Reset empties both tables and sets the radius to 150 mm. When the receiver
// stalls, the output word holds and the block waits before loading the next one.
// ----------------------------------------------------------------------------
module proximity_dedupe_point_table #(
    parameter int TABLE_DEPTH = pdpt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pdpt_pkg::t_in_item             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pdpt_pkg::t_out_item            o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pdpt_pkg::RADIUS_W-1:0]  i_cfg_data
);

    pdpt_pkg::t_ctrl_cmd  ctrl_cmd;
    pdpt_pkg::t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    pdpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (dp_status),
        .o_cmd      (ctrl_cmd),
        .o_in_stall (o_in_stall)
    );

    pdpt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctrl_cmd),
        .o_status    (dp_status),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // An accepted word closes the input until its results are under way.
    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accept");

    // The final listed entry sits in the last occupied slot.
    a_dump_last_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == pdpt_pkg::STS_ENTRY) && o_out_data.last)
        |-> (o_out_data.entry_index
             == pdpt_pkg::ENTRY_INDEX_W'(o_out_data.entry_count - 1'b1)))
        else $error("dump last marker on wrong slot");

    // An empty dump reports nothing stored and closes the item.
    a_empty_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == pdpt_pkg::STS_EMPTY))
        |-> (o_out_data.last && (o_out_data.entry_count == '0)))
        else $error("empty word malformed");

    // The controller issues at most one datapath command per cycle.
    a_ctrl_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(ctrl_cmd))
        else $error("controller issued conflicting commands");

endmodule

// ===== src/pdpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// pdpt_ctrl
// Controller state machine: sequences capture, table scan, commit, shift-up
// after a removal, result hand-off and table dump.
// ----------------------------------------------------------------------------
module pdpt_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  pdpt_pkg::t_dp_status   i_status,
    output pdpt_pkg::t_ctrl_cmd    o_cmd,
    output logic                   o_in_stall
);

    pdpt_pkg::t_state r_state;
    pdpt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdpt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdpt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = pdpt_pkg::S_START;
                end
            end
            pdpt_pkg::S_START: begin
                if (i_status.is_dump) begin
                    n_state = i_status.tbl_empty ? pdpt_pkg::S_DECIDE : pdpt_pkg::S_DUMP;
                end else begin
                    n_state = pdpt_pkg::S_SCAN;
                end
            end
            pdpt_pkg::S_SCAN: begin
                if (i_status.found || i_status.scan_done) begin
                    n_state = pdpt_pkg::S_DECIDE;
                end
            end
            pdpt_pkg::S_DECIDE: begin
                if (i_status.is_remove && i_status.found) begin
                    n_state = pdpt_pkg::S_SHIFT;
                end else begin
                    n_state = pdpt_pkg::S_EMIT;
                end
            end
            pdpt_pkg::S_SHIFT: begin
                if (i_status.shift_done) begin
                    n_state = pdpt_pkg::S_EMIT;
                end
            end
            pdpt_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = pdpt_pkg::S_IDLE;
                end
            end
            pdpt_pkg::S_DUMP: begin
                if (i_status.out_free && i_status.dump_last) begin
                    n_state = pdpt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pdpt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            pdpt_pkg::S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            pdpt_pkg::S_START: begin
                if (i_status.is_dump) begin
                    o_cmd.dump_start = !i_status.tbl_empty;
                end else begin
                    o_cmd.scan_start = 1'b1;
                end
            end
            pdpt_pkg::S_SCAN: begin
                o_cmd.scan_run = 1'b1;
            end
            pdpt_pkg::S_DECIDE: begin
                o_cmd.decide = 1'b1;
            end
            pdpt_pkg::S_SHIFT: begin
                o_cmd.shift_run = 1'b1;
            end
            pdpt_pkg::S_EMIT: begin
                o_cmd.emit_load = i_status.out_free;
            end
            pdpt_pkg::S_DUMP: begin
                o_cmd.dump_run = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== src/pdpt_dp.sv =====
// ----------------------------------------------------------------------------
// pdpt_dp
// Datapath: point memory for both tables, entry counts, match radius, the
// pipelined distance scan, the shift-up after a removal and the result
// registers.
// ----------------------------------------------------------------------------
module pdpt_dp #(
    parameter int TABLE_DEPTH = pdpt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  pdpt_pkg::t_ctrl_cmd                   i_cmd,
    output pdpt_pkg::t_dp_status                  o_status,
    input  pdpt_pkg::t_in_item                    i_in_data,
    input  logic                                  i_cfg_valid,
    input  logic [pdpt_pkg::RADIUS_W-1:0]         i_cfg_data,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output pdpt_pkg::t_out_item                   o_out_data
);

    localparam int C         = pdpt_pkg::COORD_BITS;
    localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int MEM_DEPTH = 2 ** (IDX_W + 1);
    localparam int SQ_W      = 2 * C + 1;
    localparam int SUM_W     = 2 * C + 2;
    localparam int R2_W      = 2 * pdpt_pkg::RADIUS_W;
    localparam int IW        = pdpt_pkg::ENTRY_INDEX_W;
    localparam int CW        = pdpt_pkg::ENTRY_COUNT_W;

    // Captured item.
    pdpt_pkg::t_cmd              r_cmd;
    logic                        r_tbl;
    logic signed [C-1:0]         r_x;
    logic signed [C-1:0]         r_y;

    logic [CNT_W-1:0]            r_red_cnt;
    logic [CNT_W-1:0]            r_grn_cnt;
    logic [CNT_W-1:0]            cur_cnt;
    logic [pdpt_pkg::RADIUS_W-1:0] r_radius;
    logic [R2_W-1:0]             r_r2;

    pdpt_pkg::t_point            r_mem [MEM_DEPTH];
    pdpt_pkg::t_point            r_rd_data;
    logic [CNT_W-1:0]            rd_idx;
    logic [IDX_W:0]              rd_addr;
    logic                        mem_we;
    logic [IDX_W:0]              mem_wa;
    pdpt_pkg::t_point            mem_wd;

    // Scan pipeline.
    logic [CNT_W-1:0]            r_scan_idx;
    logic                        scan_issue;
    logic                        r_p1_valid;
    logic [IDX_W-1:0]            r_p1_idx;
    logic signed [C:0]           dx;
    logic signed [C:0]           dy;
    logic signed [2*C+1:0]       prod_x;
    logic signed [2*C+1:0]       prod_y;
    logic                        r_p2_valid;
    logic [IDX_W-1:0]            r_p2_idx;
    pdpt_pkg::t_point            r_p2_pt;
    logic [SQ_W-1:0]             r_sq_x;
    logic [SQ_W-1:0]             r_sq_y;
    logic [SUM_W-1:0]            d2;
    logic                        hit;
    logic                        r_found;
    logic [IDX_W-1:0]            r_hit_idx;
    pdpt_pkg::t_point            r_hit_pt;

    // Shift-up after a removal.
    logic [CNT_W-1:0]            r_sh_idx;
    logic [CNT_W-1:0]            r_sh_end;
    logic                        r_sh_wvalid;
    logic [IDX_W-1:0]            r_sh_waddr;
    logic                        sh_more;
    logic                        shift_issue;

    // Dump.
    logic [CNT_W-1:0]            r_dmp_idx;
    logic                        dump_fire;
    logic                        dump_last;

    logic                        out_free;
    logic                        can_insert;
    pdpt_pkg::t_out_item         r_res;
    pdpt_pkg::t_out_item         r_out;
    logic                        r_out_valid;
    pdpt_pkg::t_out_item         dump_word;

    assign cur_cnt    = r_tbl ? r_grn_cnt : r_red_cnt;
    assign can_insert = cur_cnt < CNT_W'(TABLE_DEPTH);
    assign out_free   = !r_out_valid || !i_out_stall;

    assign scan_issue = i_cmd.scan_run && !r_found && (r_scan_idx < cur_cnt);

    assign sh_more     = ({1'b0, r_sh_idx} + (CNT_W + 1)'(1)) < {1'b0, r_sh_end};
    assign shift_issue = i_cmd.shift_run && sh_more;

    assign dump_fire = i_cmd.dump_run && out_free;
    assign dump_last = (r_dmp_idx + CNT_W'(1)) == cur_cnt;

    always_comb begin
        rd_idx = r_scan_idx;
        if (i_cmd.shift_run) begin
            rd_idx = r_sh_idx + CNT_W'(1);
        end else if (i_cmd.dump_start) begin
            rd_idx = '0;
        end else if (i_cmd.dump_run) begin
            rd_idx = dump_fire ? (r_dmp_idx + CNT_W'(1)) : r_dmp_idx;
        end
    end
    assign rd_addr = {r_tbl, rd_idx[IDX_W-1:0]};

    // One write port: the commit of an observe, or a shift-up step.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = {1'b0, r_sh_waddr};
        mem_wd = r_rd_data;
        if (r_sh_wvalid) begin
            mem_we = 1'b1;
        end else if (i_cmd.decide && (r_cmd == pdpt_pkg::CMD_OBSERVE)
                     && (r_found || can_insert)) begin
            mem_we = 1'b1;
            mem_wa = {r_tbl, r_found ? r_hit_idx : cur_cnt[IDX_W-1:0]};
            mem_wd = '{y: r_y, x: r_x};
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Squared distance between the captured point and the entry just read.
    assign dx     = {r_x[C-1], r_x} - {r_rd_data.x[C-1], r_rd_data.x};
    assign dy     = {r_y[C-1], r_y} - {r_rd_data.y[C-1], r_rd_data.y};
    assign prod_x = dx * dx;
    assign prod_y = dy * dy;
    assign d2     = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    assign hit    = r_p2_valid && (d2 < SUM_W'(r_r2));

    always_ff @(posedge i_clk) begin
        r_sq_x   <= prod_x[SQ_W-1:0];
        r_sq_y   <= prod_y[SQ_W-1:0];
        r_p2_idx <= r_p1_idx;
        r_p2_pt  <= r_rd_data;
        r_r2     <= r_radius * r_radius;
        if (scan_issue) begin
            r_p1_idx <= r_scan_idx[IDX_W-1:0];
        end
        if (hit && !r_found) begin
            r_hit_idx <= r_p2_idx;
            r_hit_pt  <= r_p2_pt;
        end
        if (i_cmd.capture) begin
            r_cmd <= i_in_data.command;
            r_x   <= i_in_data.x_pos;
            r_y   <= i_in_data.y_pos;
            if (i_in_data.command == pdpt_pkg::CMD_OBSERVE) begin
                r_tbl <= i_in_data.color;
            end else begin
                r_tbl <= (i_in_data.command == pdpt_pkg::CMD_DUMP_GREEN);
            end
        end
        if (shift_issue) begin
            r_sh_waddr <= r_sh_idx[IDX_W-1:0];
        end
    end

    // Control registers: counts, radius, scan and shift sequencing, output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_cnt   <= '0;
            r_grn_cnt   <= '0;
            r_radius    <= pdpt_pkg::RADIUS_RESET;
            r_scan_idx  <= '0;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_found     <= 1'b0;
            r_sh_idx    <= '0;
            r_sh_end    <= '0;
            r_sh_wvalid <= 1'b0;
            r_dmp_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_radius <= i_cfg_data;
            end

            if (i_cmd.scan_start) begin
                r_scan_idx <= '0;
                r_p1_valid <= 1'b0;
                r_p2_valid <= 1'b0;
                r_found    <= 1'b0;
            end else begin
                r_p1_valid <= scan_issue;
                r_p2_valid <= r_p1_valid;
                if (scan_issue) begin
                    r_scan_idx <= r_scan_idx + CNT_W'(1);
                end
                if (hit) begin
                    r_found <= 1'b1;
                end
            end

            r_sh_wvalid <= shift_issue;
            if (shift_issue) begin
                r_sh_idx <= r_sh_idx + CNT_W'(1);
            end

            if (i_cmd.decide) begin
                case (r_cmd)
                    pdpt_pkg::CMD_OBSERVE: begin
                        if (!r_found && can_insert) begin
                            if (r_tbl) begin
                                r_grn_cnt <= r_grn_cnt + CNT_W'(1);
                            end else begin
                                r_red_cnt <= r_red_cnt + CNT_W'(1);
                            end
                        end
                    end
                    pdpt_pkg::CMD_REMOVE: begin
                        if (r_found) begin
                            r_red_cnt <= r_red_cnt - CNT_W'(1);
                            r_sh_idx  <= CNT_W'(r_hit_idx);
                            r_sh_end  <= r_red_cnt;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cmd.dump_start) begin
                r_dmp_idx <= '0;
            end else if (dump_fire) begin
                r_dmp_idx <= r_dmp_idx + CNT_W'(1);
            end

            if (i_cmd.emit_load || dump_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        dump_word.status      = pdpt_pkg::STS_ENTRY;
        dump_word.entry_index = IW'(r_dmp_idx);
        dump_word.out_x       = r_rd_data.x;
        dump_word.out_y       = r_rd_data.y;
        dump_word.entry_count = CW'(cur_cnt);
        dump_word.last        = dump_last;
    end

    // Pending result, built in the commit cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_res.last  <= 1'b1;
            r_res.out_x <= r_x;
            r_res.out_y <= r_y;
            case (r_cmd)
                pdpt_pkg::CMD_OBSERVE: begin
                    if (r_found) begin
                        r_res.status      <= pdpt_pkg::STS_UPDATED;
                        r_res.entry_index <= IW'(r_hit_idx);
                        r_res.entry_count <= CW'(cur_cnt);
                    end else if (can_insert) begin
                        r_res.status      <= pdpt_pkg::STS_INSERTED;
                        r_res.entry_index <= IW'(cur_cnt);
                        r_res.entry_count <= CW'(cur_cnt + CNT_W'(1));
                    end else begin
                        r_res.status      <= pdpt_pkg::STS_FULL;
                        r_res.entry_index <= '0;
                        r_res.entry_count <= CW'(cur_cnt);
                    end
                end
                pdpt_pkg::CMD_REMOVE: begin
                    if (r_found) begin
                        r_res.status      <= pdpt_pkg::STS_REMOVED;
                        r_res.entry_index <= IW'(r_hit_idx);
                        r_res.out_x       <= r_hit_pt.x;
                        r_res.out_y       <= r_hit_pt.y;
                        r_res.entry_count <= CW'(cur_cnt - CNT_W'(1));
                    end else begin
                        r_res.status      <= pdpt_pkg::STS_NOT_FOUND;
                        r_res.entry_index <= '0;
                        r_res.entry_count <= CW'(cur_cnt);
                    end
                end
                default: begin
                    r_res.status      <= pdpt_pkg::STS_EMPTY;
                    r_res.entry_index <= '0;
                    r_res.out_x       <= '0;
                    r_res.out_y       <= '0;
                    r_res.entry_count <= '0;
                end
            endcase
        end
        if (i_cmd.emit_load) begin
            r_out <= r_res;
        end else if (dump_fire) begin
            r_out <= dump_word;
        end
    end

    always_comb begin
        o_status.is_dump    = (r_cmd == pdpt_pkg::CMD_DUMP_RED)
                              || (r_cmd == pdpt_pkg::CMD_DUMP_GREEN);
        o_status.is_remove  = (r_cmd == pdpt_pkg::CMD_REMOVE);
        o_status.tbl_empty  = (cur_cnt == '0);
        o_status.found      = r_found;
        o_status.scan_done  = (r_scan_idx >= cur_cnt) && !r_p1_valid && !r_p2_valid;
        o_status.shift_done = !sh_more && !r_sh_wvalid;
        o_status.out_free   = out_free;
        o_status.dump_last  = dump_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
